/* rtl/core/lat_pkg.sv */
package lat_pkg;

    // Leg count and field widths
    localparam int NUM_LEGS = 8;
    localparam int MASK_W   = 8;
    localparam int LANES    = (NUM_LEGS < MASK_W) ? NUM_LEGS : MASK_W;
    localparam int WARM_W   = 16;
    localparam int TTL_W    = 24;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [TTL_W-1:0] TTL_DEFAULT = TTL_W'(200000);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRESENT_MASK = 2'd0,
        REG_WARM_HOLD    = 2'd1,
        REG_TTL_RELOAD   = 2'd2
    } cfg_reg_t;

    typedef logic [MASK_W-1:0] mask_t;
    typedef logic [WARM_W-1:0] warm_t;
    typedef logic [TTL_W-1:0]  ttl_t;

    // Input item
    typedef struct packed {
        mask_t opens_mask;
        mask_t req_mask;
        mask_t closes_mask;
    } lat_in_t;

    // Result item
    typedef struct packed {
        mask_t      hot_mask;
        logic       any_hot;
        mask_t      outstanding_mask;
        mask_t      expired_mask;
    } lat_out_t;

    // What one lane reports for the current item
    typedef struct packed {
        logic hot;
        logic outst;
        logic expired;
    } lat_lane_res_t;

    // Per-leg inputs of one lane
    typedef struct packed {
        logic present;
        logic open;
        logic req;
        logic close;
    } lat_lane_in_t;

endpackage

/* rtl/core/lat_lane.sv */
module lat_lane (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  lat_pkg::lat_lane_in_t lane_in,
    input  lat_pkg::warm_t        warm_hold,
    input  lat_pkg::ttl_t         ttl_reload,
    output lat_pkg::lat_lane_res_t lane_res
);
    import lat_pkg::*;

    logic  outst_reg, outst_next;
    ttl_t  ttl_reg, ttl_next;
    warm_t warm_reg, warm_next;

    logic  o_open;
    ttl_t  ttl_open;
    logic  expired;

    // Per-leg update for one item
    always_comb
    begin
        o_open    = outst_reg;
        ttl_open  = ttl_reg;
        outst_next = outst_reg;
        ttl_next  = ttl_reg;
        warm_next = warm_reg;
        expired   = 1'b0;
        lane_res  = '0;

        if (lane_in.present)
        begin
            // open loads the counter only when nothing is outstanding
            if (lane_in.open)
            begin
                if (!outst_reg)
                begin
                    ttl_open = ttl_reload;
                end
                o_open = 1'b1;
            end
            if (lane_in.close)
            begin
                o_open = 1'b0;
            end

            // time-to-live countdown, self-clear at zero
            outst_next = o_open;
            ttl_next   = ttl_open;
            if (o_open && (ttl_open != '0))
            begin
                ttl_next = ttl_open - 1'b1;
                if (ttl_open == TTL_W'(1))
                begin
                    outst_next = 1'b0;
                    expired    = 1'b1;
                end
            end

            // warm countdown
            if (lane_in.req || outst_next)
            begin
                warm_next = warm_hold;
            end
            else if (warm_reg != '0)
            begin
                warm_next = warm_reg - 1'b1;
            end

            lane_res.hot     = lane_in.req || outst_next || (warm_next != '0);
            lane_res.expired = expired;
        end
        lane_res.outst = outst_next;
    end

    // State registers, updated once per accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outst_reg <= 1'b0;
            ttl_reg   <= '0;
            warm_reg  <= '0;
        end
        else if (fire)
        begin
            outst_reg <= outst_next;
            ttl_reg   <= ttl_next;
            warm_reg  <= warm_next;
        end
    end

endmodule

/* rtl/core/lat_merge.sv */
module lat_merge (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  logic                   out_ready,
    input  lat_pkg::lat_lane_res_t lane_res [lat_pkg::LANES],
    output logic                   out_valid,
    output lat_pkg::lat_out_t      out_data
);
    import lat_pkg::*;

    lat_out_t merged;
    lat_out_t data_reg;
    logic     valid_reg;

    // Gather lane bits into masks, reduce to any_hot
    always_comb
    begin
        merged = '0;
        for (int l = 0; l < LANES; l++)
        begin
            merged.hot_mask[l]         = lane_res[l].hot;
            merged.outstanding_mask[l] = lane_res[l].outst;
            merged.expired_mask[l]     = lane_res[l].expired;
        end
        merged.any_hot = |merged.hot_mask;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            data_reg <= merged;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/core/leg_activity_tracker.sv */
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready  | opens_mask, req_mask, closes_mask
// out     | output    | out_valid/out_ready| hot_mask, any_hot, outstanding_mask, expired_mask
// cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// One item per cycle while in_ready is high; its result shows in the cycle after
// acceptance, set by the single register stage after the per-leg lanes.
// Reset (async, active low) clears all leg state and loads register defaults.
// in_ready is low only while a result waits and out_ready is low; a result
// taken in the same cycle lets the next item in.
module leg_activity_tracker (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  lat_pkg::lat_in_t        in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output lat_pkg::lat_out_t       out_data,
    input  logic                    cfg_we,
    input  logic [lat_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lat_pkg::CFG_W-1:0] cfg_data
);
    import lat_pkg::*;

    mask_t present_mask_reg;
    warm_t warm_hold_reg;
    ttl_t  ttl_reload_reg;

    logic          fire;
    lat_lane_res_t lane_res [LANES];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_mask_reg <= '0;
            warm_hold_reg    <= '0;
            ttl_reload_reg   <= TTL_DEFAULT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PRESENT_MASK: present_mask_reg <= cfg_data[MASK_W-1:0];
                REG_WARM_HOLD:    warm_hold_reg    <= cfg_data[WARM_W-1:0];
                REG_TTL_RELOAD:   ttl_reload_reg   <= cfg_data[TTL_W-1:0];
                default:          ;
            endcase
        end
    end

    assign in_ready = !out_valid || out_ready;
    assign fire     = in_valid && in_ready;

    // One lane per leg
    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        lat_lane_in_t lane_in;

        assign lane_in.present = present_mask_reg[l];
        assign lane_in.open    = in_data.opens_mask[l];
        assign lane_in.req     = in_data.req_mask[l];
        assign lane_in.close   = in_data.closes_mask[l];

        lat_lane u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .fire        (fire),
            .lane_in     (lane_in),
            .warm_hold   (warm_hold_reg),
            .ttl_reload  (ttl_reload_reg),
            .lane_res    (lane_res[l])
        );
    end

    lat_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .out_ready (out_ready),
        .lane_res  (lane_res),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

/* tb/sv/leg_activity_checker.sv */
`timescale 1ns / 100ps

module leg_activity_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  lat_pkg::lat_in_t              in_data,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  lat_pkg::lat_out_t             out_data,
    input  logic                          cfg_we,
    input  logic [lat_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lat_pkg::CFG_W-1:0]     cfg_data,
    output int                            fails,
    output int                            pending
);
    import lat_pkg::*;

    // Shadow registers
    mask_t present_r;
    warm_t warm_r;
    ttl_t  ttl_r;

    // Shadow per-leg state
    logic  leg_busy [NUM_LEGS];
    ttl_t  leg_ttl  [NUM_LEGS];
    warm_t leg_warm [NUM_LEGS];

    lat_out_t leg_reports [$];
    int       mismatches;
    int       waiting;

    assign fails   = mismatches;
    assign pending = waiting;

    // Advance every leg by one beat and build the report it should produce
    task automatic step_legs(input lat_in_t beat, output lat_out_t res);
        mask_t hot;
        mask_t outst;
        mask_t expd;
        hot   = '0;
        outst = '0;
        expd  = '0;
        for (int l = 0; l < LANES; l++)
        begin
            if (present_r[l])
            begin
                if (beat.opens_mask[l])
                begin
                    // no reload while already outstanding
                    if (!leg_busy[l])
                        leg_ttl[l] = ttl_r;
                    leg_busy[l] = 1'b1;
                end
                if (beat.closes_mask[l])
                    leg_busy[l] = 1'b0;
                // a zero counter never expires
                if (leg_busy[l] && leg_ttl[l] != '0)
                begin
                    leg_ttl[l] = leg_ttl[l] - 1'b1;
                    if (leg_ttl[l] == '0)
                    begin
                        leg_busy[l] = 1'b0;
                        expd[l]     = 1'b1;
                    end
                end
                if (beat.req_mask[l] || leg_busy[l])
                    leg_warm[l] = warm_r;
                else if (leg_warm[l] != '0)
                    leg_warm[l] = leg_warm[l] - 1'b1;
                hot[l] = beat.req_mask[l] || leg_busy[l] || (leg_warm[l] != '0);
            end
            // absent legs still show their stored flag
            outst[l] = leg_busy[l];
        end
        res.hot_mask         = hot;
        res.any_hot          = |hot;
        res.outstanding_mask = outst;
        res.expired_mask     = expd;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        lat_out_t want;
        lat_out_t got;
        if (!rst_n)
        begin
            present_r = '0;
            warm_r    = '0;
            ttl_r     = TTL_DEFAULT;
            for (int l = 0; l < NUM_LEGS; l++)
            begin
                leg_busy[l] = 1'b0;
                leg_ttl[l]  = '0;
                leg_warm[l] = '0;
            end
            leg_reports.delete();
            mismatches = 0;
            waiting    = 0;
        end
        else
        begin
            // Result side: compare against the oldest prediction
            if (out_valid && out_ready)
            begin
                got = out_data;
                if (leg_reports.size() == 0)
                begin
                    $error("result item with no prediction waiting");
                    mismatches++;
                end
                else
                begin
                    want = leg_reports.pop_front();
                    if (got.hot_mask !== want.hot_mask)
                    begin
                        $error("hot_mask expected %02h actual %02h",
                               want.hot_mask, got.hot_mask);
                        mismatches++;
                    end
                    if (got.any_hot !== want.any_hot)
                    begin
                        $error("any_hot expected %0b actual %0b", want.any_hot, got.any_hot);
                        mismatches++;
                    end
                    if (got.outstanding_mask !== want.outstanding_mask)
                    begin
                        $error("outstanding_mask expected %02h actual %02h",
                               want.outstanding_mask, got.outstanding_mask);
                        mismatches++;
                    end
                    if (got.expired_mask !== want.expired_mask)
                    begin
                        $error("expired_mask expected %02h actual %02h",
                               want.expired_mask, got.expired_mask);
                        mismatches++;
                    end
                end
            end

            // Input side: predict the report for each accepted item
            if (in_valid && in_ready)
            begin
                step_legs(in_data, want);
                leg_reports.push_back(want);
            end

            // Register writes; unknown indexes are dropped
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PRESENT_MASK: present_r = cfg_data[MASK_W-1:0];
                    REG_WARM_HOLD:    warm_r    = cfg_data[WARM_W-1:0];
                    REG_TTL_RELOAD:   ttl_r     = cfg_data[TTL_W-1:0];
                    default: ;
                endcase
            end

            waiting = leg_reports.size();
        end
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;
    import lat_pkg::*;

    // Index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam int NUM_PHASES   = 15;
    localparam int PHASE_BEATS  = 102;
    localparam int CALM_PHASES  = 3;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    lat_in_t              in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b1;
    lat_out_t             out_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_PRESENT_MASK;
    logic [CFG_W-1:0]     cfg_data  = '0;

    int fails;
    int pending;
    bit calm = 1'b0;

    leg_activity_tracker u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    leg_activity_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fails     (fails),
        .pending   (pending)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("leg_activity_tracker regression: fail");
        $finish;
    end

    // Receiver back-pressure in short bursts
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
            end
            out_ready = 1'b1;
        end
    end

    // Offer one beat, return at the falling edge after it is taken.
    // in_valid is left high; the caller drops it after a batch.
    task automatic push_beat(input mask_t opens, input mask_t reqs, input mask_t closes);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid            = 1'b1;
        in_data.opens_mask  = opens;
        in_data.req_mask    = reqs;
        in_data.closes_mask = closes;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Register write; cfg_we stays high for back-to-back writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
    endtask

    // Stop offering and wait until every predicted report is back
    task automatic settle();
        int waited;
        waited   = 0;
        in_valid = 1'b0;
        while (pending != 0 && waited < 5000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (2) @(negedge clk);
    endtask

    initial
    begin : stimulus
        mask_t            opens;
        mask_t            reqs;
        mask_t            closes;
        logic [CFG_W-1:0] value;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Short counters on all legs: reload, re-open, expiry, open+close
        write_reg(REG_PRESENT_MASK, 24'h0000FF);
        write_reg(REG_WARM_HOLD,    24'd2);
        write_reg(REG_TTL_RELOAD,   24'd3);
        cfg_we = 1'b0;
        push_beat(8'h00, 8'h00, 8'h00);
        push_beat(8'hFF, 8'h00, 8'h00);
        push_beat(8'h0F, 8'h00, 8'h00);
        push_beat(8'h00, 8'hAA, 8'h00);
        push_beat(8'h33, 8'h00, 8'h3C);
        push_beat(8'h00, 8'h00, 8'h01);
        push_beat(8'h00, 8'h00, 8'h00);
        push_beat(8'h00, 8'h00, 8'h00);
        push_beat(8'h00, 8'h00, 8'h00);
        push_beat(8'hFF, 8'hFF, 8'hFF);
        settle();

        // Largest reloads; legs stay outstanding
        write_reg(REG_WARM_HOLD,   24'h00FFFF);
        write_reg(REG_TTL_RELOAD,  24'hFFFFFF);
        cfg_we = 1'b0;
        push_beat(8'hFF, 8'h00, 8'h00);
        push_beat(8'h00, 8'hFF, 8'h00);
        settle();

        // Upper legs absent and holding state, zero reloads, spare index ignored
        write_reg(REG_PRESENT_MASK, 24'hFFFF0F);
        write_reg(REG_WARM_HOLD,    24'hFF0000);
        write_reg(REG_TTL_RELOAD,   24'd0);
        write_reg(REG_SPARE,        24'hFFFFFF);
        cfg_we = 1'b0;
        push_beat(8'hFF, 8'h00, 8'hF0);
        push_beat(8'h00, 8'h00, 8'h03);
        push_beat(8'h03, 8'h00, 8'h00);
        push_beat(8'h00, 8'h00, 8'h00);
        push_beat(8'h00, 8'h00, 8'h0F);
        push_beat(8'h00, 8'hFF, 8'h00);
        push_beat(8'h00, 8'h00, 8'h00);
        settle();

        // No legs present, then every leg with a one-beat lifetime
        write_reg(REG_PRESENT_MASK, 24'd0);
        cfg_we = 1'b0;
        push_beat(8'hFF, 8'hFF, 8'h00);
        settle();
        write_reg(REG_PRESENT_MASK, 24'h0000FF);
        write_reg(REG_TTL_RELOAD,   24'd1);
        cfg_we = 1'b0;
        push_beat(8'hFF, 8'h00, 8'h00);
        push_beat(8'h00, 8'h00, 8'hF0);
        push_beat(8'h0F, 8'h00, 8'h00);
        settle();

        // Random phases, each under its own register setting
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p >= NUM_PHASES - CALM_PHASES)
                calm = 1'b1;
            settle();

            value = CFG_W'($urandom);
            case ($urandom_range(0, 5))
                0:       value[MASK_W-1:0] = 8'hFF;
                1:       value[MASK_W-1:0] = 8'h00;
                default: ;
            endcase
            write_reg(REG_PRESENT_MASK, value);

            value = CFG_W'($urandom);
            case ($urandom_range(0, 5))
                0:       value[WARM_W-1:0] = '0;
                1:       value[WARM_W-1:0] = '1;
                2:       value[WARM_W-1:0] = WARM_W'(1);
                default: value[WARM_W-1:0] = WARM_W'($urandom_range(1, 10));
            endcase
            write_reg(REG_WARM_HOLD, value);

            case ($urandom_range(0, 7))
                0:       value = '0;
                1:       value = '1;
                2:       value = CFG_W'(1);
                3:       value = CFG_W'($urandom);
                default: value = CFG_W'($urandom_range(2, 24));
            endcase
            write_reg(REG_TTL_RELOAD, value);

            if ($urandom_range(0, 3) == 0)
                write_reg(REG_SPARE, CFG_W'($urandom));
            cfg_we = 1'b0;

            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // noise: any combination of bits
                    opens  = mask_t'($urandom);
                    reqs   = mask_t'($urandom);
                    closes = mask_t'($urandom);
                end
                else
                begin
                    // sparse opens and closes so transactions live and expire
                    for (int l = 0; l < MASK_W; l++)
                    begin
                        opens[l]  = ($urandom_range(0, 4) == 0);
                        reqs[l]   = ($urandom_range(0, 2) == 0);
                        closes[l] = ($urandom_range(0, 5) == 0);
                    end
                end
                push_beat(opens, reqs, closes);
            end
        end

        settle();
        repeat (4) @(negedge clk);
        if (fails == 0 && pending == 0)
            $display("leg_activity_tracker regression: pass");
        else
            $display("leg_activity_tracker regression: fail");
        $finish;
    end

endmodule
